[hdl/frame_difference_motion_detect_assert.svh]
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FRAME_DIFFERENCE_MOTION_DETECT_ASSERT_SVH
`define FRAME_DIFFERENCE_MOTION_DETECT_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define FDMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define FDMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds through reset.
`define FDMD_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/fdmd_pkg.sv]
package fdmd_pkg;

  localparam int FRAME_PIXELS = 131072;
  localparam int ADDR_W       = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int FILL_W       = $clog2(FRAME_PIXELS + 1);
  localparam int PIX_W        = 8;
  localparam int CNT_W        = 18;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 18;

  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [FILL_W-1:0]     fill_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam pix_t   WHITE_LEVEL = 8'hFF;
  localparam count_t COUNT_MAX   = '1;

  // Configuration register indexes
  localparam cfg_idx_t REG_DIFF_THRESHOLD = 1'b0;
  localparam cfg_idx_t REG_CHANGE_LIMIT   = 1'b1;

  // Frame store write request from the compare stage
  typedef struct packed {
    logic en;
    pix_t data;
  } wr_req_t;

endpackage

[hdl/fdmd_pix_if.sv]
interface fdmd_pix_if;
  import fdmd_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel_value;
  logic frame_end;

  modport source (output valid, output pixel_value, output frame_end, input ready);
  modport sink (input valid, input pixel_value, input frame_end, output ready);
endinterface

[hdl/fdmd_res_if.sv]
interface fdmd_res_if;
  import fdmd_pkg::*;

  logic   valid;
  logic   ready;
  pix_t   diff_pixel;
  logic   frame_done;
  logic   frame_changed;
  count_t changed_total;

  modport source (
    output valid, output diff_pixel, output frame_done, output frame_changed,
    output changed_total, input ready
  );
  modport sink (
    input valid, input diff_pixel, input frame_done, input frame_changed,
    input changed_total, output ready
  );
endinterface

[hdl/fdmd_ram.sv]
module fdmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[hdl/fdmd_store.sv]
module fdmd_store (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic             rd_last,
  input  fdmd_pkg::wr_req_t wr,
  output fdmd_pkg::pix_t   old_pixel
);
  import fdmd_pkg::*;

  addr_t rd_addr;
  addr_t addr_inc;
  addr_t addr_q;
  fill_t fill;
  logic  hit;
  logic  fwd;
  pix_t  fwd_data;
  pix_t  ram_rdata;

  // Next raster address with wrap at the end of the store
  assign addr_inc = (rd_addr == addr_t'(FRAME_PIXELS - 1)) ? '0 : rd_addr + 1'b1;

  // Advance the pixel address on each accepted beat; frame end restarts it
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
    end else if (rd_en) begin
      rd_addr <= rd_last ? '0 : addr_inc;
    end
  end

  // Capture address, written-before flag and same-entry bypass with the read
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
      fwd <= 1'b0;
    end else if (rd_en) begin
      hit <= fill_t'(rd_addr) < fill;
      fwd <= wr.en && (addr_q == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_q   <= rd_addr;
      fwd_data <= wr.data;
    end
  end

  // Track how far the store has been written since reset; entries from the mark up read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr.en && (fill_t'(addr_q) == fill)) begin
      fill <= fill + 1'b1;
    end
  end

  fdmd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FRAME_PIXELS)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (addr_q),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Select bypassed, stored or reset value for the compare stage
  assign old_pixel = fwd ? fwd_data : (hit ? ram_rdata : '0);
endmodule

[hdl/fdmd_diff.sv]
module fdmd_diff (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  fdmd_pkg::cfg_idx_t  cfg_idx,
  input  fdmd_pkg::cfg_data_t cfg_data,
  input  logic                acc,
  input  fdmd_pkg::pix_t      pixel_value,
  input  logic                frame_end,
  input  fdmd_pkg::pix_t      old_pixel,
  input  logic                out_ready,
  output logic                in_ready,
  output fdmd_pkg::wr_req_t   wr,
  output logic                out_valid,
  output fdmd_pkg::pix_t      diff_pixel,
  output logic                frame_done,
  output logic                frame_changed,
  output fdmd_pkg::count_t    changed_total
);
  import fdmd_pkg::*;

  pix_t   diff_threshold;
  count_t change_limit;
  logic   s1_valid;
  pix_t   s1_pixel;
  logic   s1_last;
  logic   s1_adv;
  count_t count;
  pix_t   abs_diff;
  logic   changed;
  count_t total;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold <= pix_t'(32);
      change_limit   <= count_t'(7680);
    end else if (cfg_we) begin
      if (cfg_idx == REG_DIFF_THRESHOLD) begin
        diff_threshold <= cfg_data[PIX_W-1:0];
      end else if (cfg_idx == REG_CHANGE_LIMIT) begin
        change_limit <= cfg_data[CNT_W-1:0];
      end
    end
  end

  // Compare stage moves on when the output register is free or being drained
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pixel <= pixel_value;
      s1_last  <= frame_end;
    end
  end

  // Thresholded difference and saturating changed-pixel count
  always_comb begin
    abs_diff = (s1_pixel >= old_pixel) ? s1_pixel - old_pixel : old_pixel - s1_pixel;
    changed  = abs_diff > diff_threshold;
    total    = (changed && (count != COUNT_MAX)) ? count + 1'b1 : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (s1_adv) begin
      count <= s1_last ? '0 : total;
    end
  end

  // Write the current pixel back as the beat leaves the compare stage
  assign wr.en   = s1_adv;
  assign wr.data = s1_pixel;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_adv || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      diff_pixel    <= WHITE_LEVEL - (changed ? abs_diff : '0);
      frame_done    <= s1_last;
      frame_changed <= s1_last && (total > change_limit);
      changed_total <= total;
    end
  end
endmodule

[hdl/frame_difference_motion_detect.sv]
// Frame-difference motion detector.
// Input channel "pixels": one grey pixel per beat in raster order, frame_end
// marks the last pixel of a frame. Output channel "results": one beat per
// pixel with 255 minus the thresholded difference to the stored pixel of the
// previous frame, the running changed-pixel count, and on the frame's last
// pixel the frame_done and frame_changed flags.
// Configuration: cfg_we/cfg_idx/cfg_data write diff_threshold (index 0) and
// change_limit (index 1); write only while no pixel is in flight.
// Throughput is one pixel per cycle while results are taken: the frame store is read as a beat is
// accepted and written as it leaves the compare stage, one port of each.
// A result passes through the compare stage register, then the output register,
// before it is valid.
// Reset clears the address, the count and the store's fill mark; entries not
// yet written since reset read as zero, so no clearing pass is needed.
// When the receiver stalls the result is held in the output register and the
// compare stage can still take one more pixel; once it is full input ready drops.
module frame_difference_motion_detect (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  fdmd_pkg::cfg_idx_t  cfg_idx,
  input  fdmd_pkg::cfg_data_t cfg_data,
  fdmd_pix_if.sink            pixels,
  fdmd_res_if.source          results
);
  import fdmd_pkg::*;

  logic    acc;
  logic    in_ready;
  wr_req_t wr;
  pix_t    old_pixel;

  // Accept a pixel beat
  assign acc          = pixels.valid && in_ready;
  assign pixels.ready = in_ready;

  fdmd_store u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (acc),
    .rd_last   (pixels.frame_end),
    .wr        (wr),
    .old_pixel (old_pixel)
  );

  fdmd_diff u_diff (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .acc           (acc),
    .pixel_value   (pixels.pixel_value),
    .frame_end     (pixels.frame_end),
    .old_pixel     (old_pixel),
    .out_ready     (results.ready),
    .in_ready      (in_ready),
    .wr            (wr),
    .out_valid     (results.valid),
    .diff_pixel    (results.diff_pixel),
    .frame_done    (results.frame_done),
    .frame_changed (results.frame_changed),
    .changed_total (results.changed_total)
  );
endmodule

[hdl/fdmd_checker.sv]
`include "frame_difference_motion_detect_assert.svh"

module fdmd_checker (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_ready,
  input logic             res_frame_done,
  input logic             res_frame_changed,
  input fdmd_pkg::count_t res_changed_total
);
  import fdmd_pkg::*;

  // Hold a result beat until it is taken
  `FDMD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result beat dropped")

  // Frame verdict appears only on the closing beat
  `FDMD_ASSERT_IMP(a_changed_on_done, res_valid && res_frame_changed, res_frame_done, "frame_changed without frame_done")

  // Count restarts after a frame closes
  `FDMD_ASSERT_NEXT(a_count_restart, res_valid && res_ready && res_frame_done, !res_valid || (res_changed_total <= count_t'(1)), "count not cleared at frame end")

  // No result right after reset
  `FDMD_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !res_valid, "result valid after reset")
endmodule

bind frame_difference_motion_detect fdmd_checker u_fdmd_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (results.valid),
  .res_ready         (results.ready),
  .res_frame_done    (results.frame_done),
  .res_frame_changed (results.frame_changed),
  .res_changed_total (results.changed_total)
);
